@@ rtl/slice_rms_peak_statistics_top_macros.svh @@
// Assertion macros shared by the slice statistics checker.
`ifndef SLICE_RMS_PEAK_STATISTICS_TOP_MACROS_SVH
`define SLICE_RMS_PEAK_STATISTICS_TOP_MACROS_SVH

// Implication that is checked on every clock edge outside reset.
`define SRPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/srps_pkg.sv @@
// Shared constants and control types of the slice statistics block.
`timescale 1ns / 1ps
`default_nettype none
package srps_pkg;
	localparam int SAMPLE_W    = 16;
	localparam int SQ_W        = 2 * SAMPLE_W;
	localparam int SUM_W       = 43;
	localparam int CNT_W       = 13;
	localparam int MAX_SAMPLES = 4096;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_W       = SQ_W + CNT_W;
	localparam int DVD_W       = NUM_W + 2 * FRAC_BITS;
	localparam int RAD_W       = 46;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int SREM_W      = ROOT_W + 3;
	localparam int DIV_STEPS   = DVD_W;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int STEP_W      = 7;
	localparam int RMS_W       = 16;
	localparam int RSSQ_W      = 22;
	localparam int P2P_W       = 16;
	localparam int RATIO_W     = 23;

	localparam logic DIV_MEAN  = 1'b0;
	localparam logic DIV_RATIO = 1'b1;
	localparam logic SQ_QUO    = 1'b0;
	localparam logic SQ_SUM    = 1'b1;

	typedef struct packed {
		logic acc;
		logic clear;
		logic mul_pp;
		logic mul_num;
		logic div_load;
		logic div_sel;
		logic div_step;
		logic sq_load;
		logic sq_sel;
		logic sq_step;
		logic st_rms;
		logic st_rssq;
		logic st_ratio;
	} cmd_t;

	typedef struct packed {
		logic sum_zero;
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/srps_datapath.sv @@
// Datapath: slice accumulators, shared restoring divider and shared square-root unit.
`timescale 1ns / 1ps
`default_nettype none
module srps_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  srps_pkg::cmd_t                      cmd,
	input  wire  [srps_pkg::SAMPLE_W-1:0]       sample,
	output srps_pkg::stat_t                     stat,
	output logic [srps_pkg::RMS_W-1:0]          rms_value,
	output logic [srps_pkg::RSSQ_W-1:0]         rssq_value,
	output logic [srps_pkg::P2P_W-1:0]          peak_to_peak,
	output logic [srps_pkg::RATIO_W-1:0]        peak_to_rms,
	output logic                                rms_is_zero,
	output logic [srps_pkg::CNT_W-1:0]          sample_count,
	output logic                                too_long
);
	logic        [srps_pkg::SQ_W-1:0]     sq_s1;
	logic                                 sq_vld_s1;
	logic        [srps_pkg::SUM_W-1:0]    sum_q;
	logic        [srps_pkg::CNT_W-1:0]    cnt_q;
	logic signed [srps_pkg::SAMPLE_W-1:0] lo_q, hi_q;
	logic        [srps_pkg::SAMPLE_W-1:0] peak_q;
	logic                                 ovf_q;
	logic        [srps_pkg::SQ_W-1:0]     pp_q;
	logic        [srps_pkg::NUM_W-1:0]    num_q;
	logic        [srps_pkg::DVD_W-1:0]    dvd_q, quo_q;
	logic        [srps_pkg::SUM_W-1:0]    den_q;
	logic        [srps_pkg::SUM_W-1:0]    rem_q;
	logic        [srps_pkg::RAD_W-1:0]    rad_q;
	logic        [srps_pkg::SREM_W-1:0]   srem_q;
	logic        [srps_pkg::ROOT_W-1:0]   root_q;
	logic        [srps_pkg::RMS_W-1:0]    rms_q;
	logic        [srps_pkg::RSSQ_W-1:0]   rssq_q;
	logic        [srps_pkg::RATIO_W-1:0]  ratio_q;

	logic signed [srps_pkg::SAMPLE_W-1:0] s;
	logic        [srps_pkg::SAMPLE_W-1:0] mag;
	logic        [srps_pkg::SUM_W:0]      rem_sh, rem_sub;
	logic        [srps_pkg::SREM_W-1:0]   st, trial, st_sub;
	logic signed [srps_pkg::SAMPLE_W:0]   p2p_full;

	assign s   = signed'(sample);
	assign mag = s[srps_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;

	// Accumulation: the square is registered and added to the sum in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sq_s1     <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			peak_q    <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.clear) begin
			sq_vld_s1 <= 1'b0;
			sum_q     <= '0;
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			peak_q    <= '0;
			ovf_q     <= 1'b0;
		end else begin
			sq_vld_s1 <= 1'b0;
			if (sq_vld_s1) begin
				sum_q <= sum_q + srps_pkg::SUM_W'(sq_s1);
			end
			if (cmd.acc) begin
				if (cnt_q < srps_pkg::CNT_W'(srps_pkg::MAX_SAMPLES)) begin
					sq_vld_s1 <= 1'b1;
					sq_s1     <= mag * mag;
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == '0 || s < lo_q) lo_q <= s;
					if (cnt_q == '0 || s > hi_q) hi_q <= s;
					if (mag > peak_q) peak_q <= mag;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign rem_sh  = {rem_q, dvd_q[srps_pkg::DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign st     = {srem_q[srps_pkg::SREM_W-3:0], rad_q[srps_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign st_sub = st - trial;

	always_ff @(posedge clk) begin
		if (cmd.mul_pp) begin
			pp_q <= peak_q * peak_q;
		end
		if (cmd.mul_num) begin
			num_q <= pp_q * cnt_q;
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= '0;
			if (cmd.div_sel == srps_pkg::DIV_RATIO) begin
				dvd_q <= {num_q, {(2 * srps_pkg::FRAC_BITS){1'b0}}};
				den_q <= sum_q;
			end else begin
				dvd_q <= srps_pkg::DVD_W'(sum_q);
				den_q <= srps_pkg::SUM_W'(cnt_q);
			end
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[srps_pkg::DVD_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sub[srps_pkg::SUM_W-1:0];
				quo_q <= {quo_q[srps_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[srps_pkg::SUM_W-1:0];
				quo_q <= {quo_q[srps_pkg::DVD_W-2:0], 1'b0};
			end
		end
		if (cmd.sq_load) begin
			srem_q <= '0;
			root_q <= '0;
			if (cmd.sq_sel == srps_pkg::SQ_SUM) begin
				rad_q <= srps_pkg::RAD_W'(sum_q);
			end else begin
				rad_q <= quo_q[srps_pkg::RAD_W-1:0];
			end
		end else if (cmd.sq_step) begin
			rad_q <= {rad_q[srps_pkg::RAD_W-3:0], 2'b00};
			if (st >= trial) begin
				srem_q <= st_sub;
				root_q <= {root_q[srps_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= st;
				root_q <= {root_q[srps_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.st_rms) begin
			rms_q <= root_q[srps_pkg::RMS_W-1:0];
		end
		if (cmd.st_rssq) begin
			rssq_q <= root_q[srps_pkg::RSSQ_W-1:0];
		end
		if (cmd.st_ratio) begin
			ratio_q <= (sum_q == '0) ? '0 : root_q[srps_pkg::RATIO_W-1:0];
		end
	end

	assign p2p_full      = {hi_q[srps_pkg::SAMPLE_W-1], hi_q} - {lo_q[srps_pkg::SAMPLE_W-1], lo_q};
	assign stat.sum_zero = (sum_q == '0);
	assign rms_value     = rms_q;
	assign rssq_value    = rssq_q;
	assign peak_to_peak  = p2p_full[srps_pkg::P2P_W-1:0];
	assign peak_to_rms   = ratio_q;
	assign rms_is_zero   = (sum_q == '0);
	assign sample_count  = cnt_q;
	assign too_long      = ovf_q;
endmodule
`default_nettype wire

@@ rtl/srps_ctrl.sv @@
// Controller: sequences accumulation, division, square roots and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module srps_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             in_last,
	input  wire             out_ready,
	input  srps_pkg::stat_t stat,
	output logic            in_ready,
	output logic            out_valid,
	output srps_pkg::cmd_t  cmd
);
	localparam logic [3:0] ST_ACC   = 4'd0;
	localparam logic [3:0] ST_FLUSH = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_MUL2  = 4'd3;
	localparam logic [3:0] ST_DIV1  = 4'd4;
	localparam logic [3:0] ST_SQ1L  = 4'd5;
	localparam logic [3:0] ST_SQ1   = 4'd6;
	localparam logic [3:0] ST_SQ2L  = 4'd7;
	localparam logic [3:0] ST_SQ2   = 4'd8;
	localparam logic [3:0] ST_DIV2L = 4'd9;
	localparam logic [3:0] ST_DIV2  = 4'd10;
	localparam logic [3:0] ST_SQ3L  = 4'd11;
	localparam logic [3:0] ST_SQ3   = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0]                    state_q, state_d;
	logic [srps_pkg::STEP_W-1:0]   step_q;
	logic                          div_end, sq_end, in_fire;

	assign in_ready  = (state_q == ST_ACC);
	assign out_valid = (state_q == ST_OUT);
	assign in_fire   = in_valid && in_ready;
	assign div_end   = (step_q == srps_pkg::STEP_W'(srps_pkg::DIV_STEPS - 1));
	assign sq_end    = (step_q == srps_pkg::STEP_W'(srps_pkg::SQRT_STEPS - 1));

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_ACC: begin
				cmd.acc = in_fire;
				if (in_fire && in_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_MUL;
			ST_MUL: begin
				cmd.mul_pp = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_num  = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel  = srps_pkg::DIV_MEAN;
				state_d      = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				if (div_end) state_d = ST_SQ1L;
			end
			ST_SQ1L: begin
				cmd.sq_load = 1'b1;
				cmd.sq_sel  = srps_pkg::SQ_QUO;
				state_d     = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.sq_step = 1'b1;
				if (sq_end) state_d = ST_SQ2L;
			end
			ST_SQ2L: begin
				cmd.st_rms  = 1'b1;
				cmd.sq_load = 1'b1;
				cmd.sq_sel  = srps_pkg::SQ_SUM;
				state_d     = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.sq_step = 1'b1;
				if (sq_end) state_d = ST_DIV2L;
			end
			ST_DIV2L: begin
				cmd.st_rssq  = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel  = srps_pkg::DIV_RATIO;
				// An all-zero slice has no ratio to compute.
				state_d      = stat.sum_zero ? ST_FIN : ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
				if (div_end) state_d = ST_SQ3L;
			end
			ST_SQ3L: begin
				cmd.sq_load = 1'b1;
				cmd.sq_sel  = srps_pkg::SQ_QUO;
				state_d     = ST_SQ3;
			end
			ST_SQ3: begin
				cmd.sq_step = 1'b1;
				if (sq_end) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.st_ratio = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					cmd.clear = 1'b1;
					state_d   = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else if (cmd.div_step || cmd.sq_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/slice_rms_peak_statistics_top.sv @@
// Slice RMS, RSSQ, peak-to-peak and crest factor: samples enter at one per cycle
// while accumulating. After the last item of a slice the shared divider and
// square-root unit run: mean division, two roots, ratio division, ratio root,
// then the result waits in place until taken (all-zero slices skip the last two).
// Input is held off from the last sample until the result is taken.
// Asynchronous active-low reset clears the accumulators and the controller.
`timescale 1ns / 1ps
`default_nettype none
module slice_rms_peak_statistics_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [15:0] sample
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [15:0] rms_value, [37:16] rssq_value, [53:38] peak_to_peak,
	// [76:54] peak_to_rms, [89:77] sample_count, [95:90] zero
	output logic [95:0] m_tdata,
	output logic [1:0]  m_tuser   // [0] rms_is_zero, [1] too_long
);
	srps_pkg::cmd_t  cmd;
	srps_pkg::stat_t stat;

	logic [srps_pkg::RMS_W-1:0]   rms_value;
	logic [srps_pkg::RSSQ_W-1:0]  rssq_value;
	logic [srps_pkg::P2P_W-1:0]   peak_to_peak;
	logic [srps_pkg::RATIO_W-1:0] peak_to_rms;
	logic                         rms_is_zero;
	logic [srps_pkg::CNT_W-1:0]   sample_count;
	logic                         too_long;

	srps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.stat      (stat),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	srps_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (s_tdata),
		.stat         (stat),
		.rms_value    (rms_value),
		.rssq_value   (rssq_value),
		.peak_to_peak (peak_to_peak),
		.peak_to_rms  (peak_to_rms),
		.rms_is_zero  (rms_is_zero),
		.sample_count (sample_count),
		.too_long     (too_long)
	);

	assign m_tdata = {6'd0, sample_count, peak_to_rms, peak_to_peak, rssq_value, rms_value};
	assign m_tuser = {too_long, rms_is_zero};
endmodule
`default_nettype wire

@@ rtl/srps_checker.sv @@
// Port-level checker for the slice statistics block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "slice_rms_peak_statistics_top_macros.svh"
module srps_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [15:0] s_tdata,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata,
	input wire [1:0]  m_tuser
);
	`SRPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`SRPS_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready, "input taken while a result is pending")
	`SRPS_ASSERT_IMPL(a_zero_ratio, m_tvalid && m_tuser[0], m_tdata[76:54] == 23'd0, "ratio nonzero for zero rms")
	`SRPS_ASSERT_IMPL(a_count_nz, m_tvalid, m_tdata[89:77] != 13'd0, "result with empty slice")
	`SRPS_ASSERT_NEXT(a_last_stops, s_tvalid && s_tready && s_tlast, !s_tready, "input accepted right after last item")
endmodule

bind slice_rms_peak_statistics_top srps_checker u_srps_checker (.*);
`default_nettype wire

@@ bench/tb_slice_rms_peak_statistics_top.sv @@
// Self-checking testbench for the slice RMS, RSSQ and peak statistics block.
`timescale 1ns / 1ps
module tb_slice_rms_peak_statistics_top;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [srps_pkg::RMS_W-1:0]   rms;
		logic [srps_pkg::RSSQ_W-1:0]  rssq;
		logic [srps_pkg::P2P_W-1:0]   p2p;
		logic [srps_pkg::RATIO_W-1:0] crest;
		logic                         rms_zero;
		logic [srps_pkg::CNT_W-1:0]   count;
		logic                         too_long;
	} slice_stats_t;

	typedef struct {
		logic [15:0]  sample;
		logic         last;
		logic         typed;
		slice_stats_t stats;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;

	slice_stats_t pending_stats[$];
	int           mismatches = 0;
	int           cycles = 0;
	logic         steady = 1'b0;

	// Running statistics of the slice in progress.
	logic [srps_pkg::SUM_W-1:0]           acc_sum = '0;
	logic [srps_pkg::CNT_W-1:0]           acc_count = '0;
	logic signed [srps_pkg::SAMPLE_W-1:0] acc_low = '0;
	logic signed [srps_pkg::SAMPLE_W-1:0] acc_high = '0;
	logic [srps_pkg::SAMPLE_W-1:0]        acc_peak = '0;
	logic                                 acc_over = 1'b0;

	slice_rms_peak_statistics_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] root;
		logic [127:0] bit_w;
		root = '0;
		bit_w = 128'd1 << 126;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v = v - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root[63:0];
	endfunction

	// Folds one sample into the slice and returns 1 with the statistics on the last one.
	function automatic logic accumulate_sample(input logic [15:0] raw, input logic last,
			output slice_stats_t stats);
		logic signed [srps_pkg::SAMPLE_W-1:0] s;
		logic [srps_pkg::SAMPLE_W:0]          mag;
		logic [127:0]                         quo;
		s = raw;
		mag = (s < 0) ? -{s[srps_pkg::SAMPLE_W-1], s} : {1'b0, s};
		if (acc_count < srps_pkg::MAX_SAMPLES) begin
			if (acc_count == 0 || s < acc_low)
				acc_low = s;
			if (acc_count == 0 || s > acc_high)
				acc_high = s;
			if (mag > acc_peak)
				acc_peak = mag;
			acc_sum = acc_sum + mag * mag;
			acc_count = acc_count + 1;
		end else begin
			acc_over = 1'b1;
		end
		stats = '0;
		if (!last)
			return 1'b0;
		stats.rms = floor_sqrt(acc_sum / acc_count);
		stats.rssq = floor_sqrt(acc_sum);
		stats.p2p = 32'(int'(acc_high) - int'(acc_low));
		stats.rms_zero = (acc_sum == 0);
		if (acc_sum != 0) begin
			// The crest factor uses the exact RMS, hence the square root of a scaled ratio.
			quo = ((128'(acc_peak) * acc_peak * acc_count) << (2 * srps_pkg::FRAC_BITS))
				/ acc_sum;
			stats.crest = floor_sqrt(quo);
		end
		stats.count = acc_count;
		stats.too_long = acc_over;
		acc_sum = '0;
		acc_count = '0;
		acc_low = '0;
		acc_high = '0;
		acc_peak = '0;
		acc_over = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_sample(input logic [15:0] raw, input logic last,
			input logic typed, input slice_stats_t typed_stats);
		slice_stats_t stats;
		while (!steady && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		if (accumulate_sample(raw, last, stats))
			pending_stats.push_back(typed ? typed_stats : stats);
	endtask

	task automatic send_slice(input int len, input int style);
		logic [15:0] raw;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: raw = $urandom;
				1: raw = $urandom_range(7) - 4;
				2: raw = $urandom_range(1) ? 16'h8000 : 16'h7fff;
				3: raw = 16'h0000;
				default: raw = $urandom_range(2000) - 1000;
			endcase
			send_sample(raw, i == len - 1, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("** slice_rms_peak_statistics_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		slice_stats_t got;
		slice_stats_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.rms = m_tdata[15:0];
			got.rssq = m_tdata[37:16];
			got.p2p = m_tdata[53:38];
			got.crest = m_tdata[76:54];
			got.count = m_tdata[89:77];
			got.rms_zero = m_tuser[0];
			got.too_long = m_tuser[1];
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", got);
			end else begin
				want = pending_stats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: rms %0d/%0d rssq %0d/%0d p2p %0d/%0d crest %0d/%0d zero %b/%b count %0d/%0d too_long %b/%b (expected/actual)",
							want.rms, got.rms, want.rssq, got.rssq, want.p2p, got.p2p,
							want.crest, got.crest, want.rms_zero, got.rms_zero,
							want.count, got.count, want.too_long, got.too_long);
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		int   drain;
		// Single-sample slices have results that follow directly from the definitions.
		rows.push_back('{16'h0000, 1'b1, 1'b1, '{0, 0, 0, 0, 1'b1, 1, 1'b0}});
		rows.push_back('{16'h8000, 1'b1, 1'b1, '{32768, 32768, 0, 65536, 1'b0, 1, 1'b0}});
		rows.push_back('{16'h7fff, 1'b1, 1'b1, '{32767, 32767, 0, 65536, 1'b0, 1, 1'b0}});
		rows.push_back('{16'hffff, 1'b1, 1'b1, '{1, 1, 0, 65536, 1'b0, 1, 1'b0}});
		rows.push_back('{16'h8000, 1'b0, 1'b0, '0});
		rows.push_back('{16'h7fff, 1'b1, 1'b0, '0});
		rows.push_back('{16'h0000, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0000, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0000, 1'b1, 1'b0, '0});
		rows.push_back('{16'h0000, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0000, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0064, 1'b1, 1'b0, '0});
		rows.push_back('{16'h0005, 1'b0, 1'b0, '0});
		rows.push_back('{16'hfffb, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0003, 1'b0, 1'b0, '0});
		rows.push_back('{16'h0001, 1'b1, 1'b0, '0});
		rows.push_back('{16'h5555, 1'b0, 1'b0, '0});
		rows.push_back('{16'haaaa, 1'b1, 1'b0, '0});
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_sample(rows[i].sample, rows[i].last, rows[i].typed, rows[i].stats);

		for (int n = 0; n < 50; n++) begin
			if (n == 20) begin
				s_tvalid <= 1'b0;
				while (pending_stats.size() != 0)
					@(posedge clk);
			end
			steady = (n >= 30 && n < 38);
			send_slice($urandom_range(1, 15), $urandom_range(4));
		end
		steady = 1'b0;
		for (int n = 0; n < 10; n++)
			send_slice($urandom_range(1, 15), $urandom_range(4));
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (pending_stats.size() != 0)
			@(posedge clk);
		for (drain = 0; drain < DRAIN_CYCLES; drain++)
			@(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("** slice_rms_peak_statistics_top: PASSED **");
		else
			$display("** slice_rms_peak_statistics_top: FAILED **");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/srps_pkg.sv
rtl/srps_datapath.sv
rtl/srps_ctrl.sv
rtl/slice_rms_peak_statistics_top.sv
rtl/srps_checker.sv
bench/tb_slice_rms_peak_statistics_top.sv
